@@ src/exp_log_polynomial_evaluator_defines.svh @@
// Assertion macros for the exp log polynomial evaluator.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef EXP_LOG_POLYNOMIAL_EVALUATOR_DEFINES_SVH
`define EXP_LOG_POLYNOMIAL_EVALUATOR_DEFINES_SVH

// same-cycle implication
`define ELP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ELP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/elp_pkg.sv @@
// Shared types and constants of the exp log polynomial evaluator.
// No dependencies.
package elp_pkg;

    localparam int TEMP_W    = 24;
    localparam int COEF_W    = 32;
    localparam int LN_W      = 29;
    localparam int OUT_W     = 48;
    localparam int SUM_W     = 34;
    localparam int K_W       = 10;
    localparam int COEF_REGS = 6;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int LOG_ITERS = 24;
    localparam int EXP_TERMS = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE  = 3'd1;

    localparam logic [31:0]      LN2_Q32   = 32'hB172_17F8;
    localparam logic [31:0]      EXP_RECIP = 32'(64'h8000_0000_0000_0000 / 64'(LN2_Q32));
    localparam logic [OUT_W-1:0] OUT_MAX   = '1;

    typedef struct packed {
        logic valid;
        logic invalid;
    } t_flags;

endpackage

@@ src/exp_log_polynomial_evaluator.sv @@
// Throughput: one temperature per cycle; the pipeline holds only when its last
// stage is full and the output register waits on m_axis_tready.
// Reset: synchronous active-low; clears valid bits, coef_count to 1, coefficients to 0.
// Top level: config registers, log, Horner and exp pipelines, output register.
// Depends on elp_pkg, elp_log, elp_horner, elp_exp and the defines header.
`include "exp_log_polynomial_evaluator_defines.svh"

module exp_log_polynomial_evaluator #(
    parameter int MAX_COEFS = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [elp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [23:0]                         s_axis_tdata,   // [23:0] temperature
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [47:0]                         m_axis_tdata,   // [47:0] integral_value
    output logic [1:0]                          m_axis_tuser    // [0] overflow, [1] invalid
);

    logic [elp_pkg::CNT_W-1:0]         r_coef_count;
    logic signed [elp_pkg::COEF_W-1:0] r_coef [elp_pkg::COEF_REGS];
    logic [elp_pkg::CNT_W-1:0]         w_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_count <= elp_pkg::CNT_W'(1);
            for (int i = 0; i < elp_pkg::COEF_REGS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == elp_pkg::CFG_COEF_COUNT) begin
                r_coef_count <= i_cfg_data[elp_pkg::CNT_W-1:0];
            end
            for (int i = 0; i < elp_pkg::COEF_REGS; i++) begin
                if (i_cfg_index == elp_pkg::CFG_COEF_BASE + elp_pkg::CFG_IDX_W'(i)) begin
                    r_coef[i] <= $signed(i_cfg_data);
                end
            end
        end
    end

    always_comb begin
        if (r_coef_count == '0) begin
            w_count = elp_pkg::CNT_W'(1);
        end else if (r_coef_count > elp_pkg::CNT_W'(MAX_COEFS)) begin
            w_count = elp_pkg::CNT_W'(MAX_COEFS);
        end else begin
            w_count = r_coef_count;
        end
    end

    logic                              w_en;
    elp_pkg::t_flags                   w_log_flg;
    logic signed [elp_pkg::LN_W-1:0]   w_ln;
    elp_pkg::t_flags                   w_hor_flg;
    logic signed [elp_pkg::COEF_W-1:0] w_acc;
    elp_pkg::t_flags                   w_exp_flg;
    logic                              w_exp_ovf;
    logic [elp_pkg::OUT_W-1:0]         w_exp_data;

    logic                      r_out_valid;
    logic [elp_pkg::OUT_W-1:0] r_out_data;
    logic                      r_out_ovf;
    logic                      r_out_inv;

    assign w_en          = !w_exp_flg.valid || !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    elp_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_temp  (s_axis_tdata),
        .o_flags (w_log_flg),
        .o_ln    (w_ln)
    );

    elp_horner #(
        .MAX_COEFS (MAX_COEFS)
    ) u_horner (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_flags      (w_log_flg),
        .i_ln         (w_ln),
        .i_coef_count (w_count),
        .i_coef       (r_coef),
        .o_flags      (w_hor_flg),
        .o_acc        (w_acc)
    );

    elp_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_flags (w_hor_flg),
        .i_y     (w_acc),
        .o_flags (w_exp_flg),
        .o_ovf   (w_exp_ovf),
        .o_data  (w_exp_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= w_exp_flg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            r_out_data <= w_exp_data;
            r_out_ovf  <= w_exp_ovf;
            r_out_inv  <= w_exp_flg.invalid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = {r_out_inv, r_out_ovf};

    logic w_inv_ok;
    logic w_ovf_ok;
    logic w_held;

    assign w_inv_ok = (r_out_data == '0) && !r_out_ovf;
    assign w_ovf_ok = (r_out_data == elp_pkg::OUT_MAX) && !r_out_inv;
    assign w_held   = r_out_valid && !m_axis_tready && w_exp_flg.valid;

    `ELP_ASSERT_NOW(a_invalid_zero, r_out_valid && r_out_inv, w_inv_ok, "invalid result not zero")
    `ELP_ASSERT_NOW(a_ovf_max, r_out_valid && r_out_ovf, w_ovf_ok, "overflow not saturated")
    `ELP_ASSERT_NOW(a_stall_cause, !s_axis_tready, w_held, "pipeline held without a full output")

endmodule

@@ src/elp_log.sv @@
// Natural log stage chain: normalize, 24 squaring stages, scale by ln 2.
// Depends on elp_pkg.
module elp_log (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [elp_pkg::TEMP_W-1:0]          i_temp,
    output elp_pkg::t_flags                     o_flags,
    output logic signed [elp_pkg::LN_W-1:0]     o_ln
);

    localparam int N = elp_pkg::LOG_ITERS;

    logic [4:0]              w_k;
    logic [30:0]             w_x0;
    logic [30:0]             s_x    [0:N];
    logic [4:0]              s_k    [0:N];
    logic [N-1:0]            s_frac [0:N];
    elp_pkg::t_flags         s_flg  [0:N];

    always_comb begin
        w_k = 5'd0;
        for (int i = 0; i < elp_pkg::TEMP_W; i++) begin
            if (i_temp[i]) begin
                w_k = 5'(i);
            end
        end
    end

    assign w_x0 = 31'(i_temp) << (5'd30 - w_k);

    logic [30:0]     r_x0;
    logic [4:0]      r_k0;
    elp_pkg::t_flags r_flg0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flg0 <= '0;
        end else if (i_en) begin
            r_flg0 <= '{valid: i_valid, invalid: (i_temp == '0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0 <= w_x0;
            r_k0 <= w_k;
        end
    end

    assign s_x[0]    = r_x0;
    assign s_k[0]    = r_k0;
    assign s_frac[0] = '0;
    assign s_flg[0]  = r_flg0;

    for (genvar g = 0; g < N; g++) begin : g_sq
        logic [61:0]     w_sq;
        logic [31:0]     w_y;
        logic [30:0]     n_x;
        logic [30:0]     r_x;
        logic [4:0]      r_k;
        logic [N-1:0]    r_frac;
        elp_pkg::t_flags r_flg;

        assign w_sq = 62'(s_x[g]) * 62'(s_x[g]);
        assign w_y  = w_sq[61:30];
        assign n_x  = w_y[31] ? w_y[31:1] : w_y[30:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_flg <= '0;
            end else if (i_en) begin
                r_flg <= s_flg[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x    <= n_x;
                r_k    <= s_k[g];
                r_frac <= {s_frac[g][N-2:0], w_y[31]};
            end
        end

        assign s_x[g+1]    = r_x;
        assign s_k[g+1]    = r_k;
        assign s_frac[g+1] = r_frac;
        assign s_flg[g+1]  = r_flg;
    end

    logic signed [elp_pkg::LN_W-1:0] w_l2;
    logic signed [32:0]              w_ln2;
    logic signed [61:0]              n_lnp;
    logic signed [61:0]              r_lnp;
    logic [61:0]                     w_rnd;
    elp_pkg::t_flags                 r_flg_p;
    logic signed [elp_pkg::LN_W-1:0] r_ln;
    elp_pkg::t_flags                 r_flg_l;

    assign w_l2  = $signed({s_k[N] - 5'd8, s_frac[N]});
    assign w_ln2 = $signed({1'b0, elp_pkg::LN2_Q32});
    assign n_lnp = w_l2 * w_ln2;
    assign w_rnd = r_lnp + 62'h8000_0000 - 62'(r_lnp[61]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flg_p <= '0;
            r_flg_l <= '0;
        end else if (i_en) begin
            r_flg_p <= s_flg[N];
            r_flg_l <= r_flg_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lnp <= n_lnp;
            r_ln  <= $signed(w_rnd[60:32]);
        end
    end

    assign o_flags = r_flg_l;
    assign o_ln    = r_ln;

endmodule

@@ src/elp_horner.sv @@
// Horner evaluation of the polynomial, one multiply and one add stage per step.
// Depends on elp_pkg.
module elp_horner #(
    parameter int MAX_COEFS = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  elp_pkg::t_flags                     i_flags,
    input  logic signed [elp_pkg::LN_W-1:0]     i_ln,
    input  logic [elp_pkg::CNT_W-1:0]           i_coef_count,
    input  logic signed [elp_pkg::COEF_W-1:0]   i_coef [elp_pkg::COEF_REGS],
    output elp_pkg::t_flags                     o_flags,
    output logic signed [elp_pkg::COEF_W-1:0]   o_acc
);

    localparam int STEPS = MAX_COEFS - 1;

    logic signed [elp_pkg::COEF_W-1:0] s_acc [0:STEPS];
    logic signed [elp_pkg::LN_W-1:0]   s_ln  [0:STEPS];
    elp_pkg::t_flags                   s_flg [0:STEPS];

    assign s_acc[0] = i_coef[0];
    assign s_ln[0]  = i_ln;
    assign s_flg[0] = i_flags;

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic signed [60:0]                n_prod;
        logic signed [60:0]                r_prod;
        logic signed [elp_pkg::COEF_W-1:0] r_acc_a;
        logic signed [elp_pkg::LN_W-1:0]   r_ln_a;
        elp_pkg::t_flags                   r_flg_a;
        logic [60:0]                       w_rnd;
        logic signed [36:0]                w_sh;
        logic signed [37:0]                w_sum;
        logic signed [elp_pkg::COEF_W-1:0] n_acc;
        logic signed [elp_pkg::COEF_W-1:0] r_acc;
        logic signed [elp_pkg::LN_W-1:0]   r_ln;
        elp_pkg::t_flags                   r_flg;

        assign n_prod = s_acc[g] * s_ln[g];
        assign w_rnd  = r_prod + 61'h80_0000 - 61'(r_prod[60]);
        assign w_sh   = $signed(w_rnd[60:24]);
        assign w_sum  = 38'(w_sh) + 38'(i_coef[g+1]);

        always_comb begin
            if (elp_pkg::CNT_W'(g + 1) >= i_coef_count) begin
                n_acc = r_acc_a;
            end else if (w_sum > 38'sd2147483647) begin
                n_acc = 32'sh7FFF_FFFF;
            end else if (w_sum < -38'sd2147483648) begin
                n_acc = 32'sh8000_0000;
            end else begin
                n_acc = w_sum[31:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_flg_a <= '0;
                r_flg   <= '0;
            end else if (i_en) begin
                r_flg_a <= s_flg[g];
                r_flg   <= r_flg_a;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_prod  <= n_prod;
                r_acc_a <= s_acc[g];
                r_ln_a  <= s_ln[g];
                r_acc   <= n_acc;
                r_ln    <= r_ln_a;
            end
        end

        assign s_acc[g+1] = r_acc;
        assign s_ln[g+1]  = r_ln;
        assign s_flg[g+1] = r_flg;
    end

    assign o_flags = s_flg[STEPS];
    assign o_acc   = s_acc[STEPS];

endmodule

@@ src/elp_exp.sv @@
// Exponential: range reduction by ln 2, pipelined Taylor series, final shift.
// Depends on elp_pkg.
module elp_exp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  elp_pkg::t_flags                     i_flags,
    input  logic signed [elp_pkg::COEF_W-1:0]   i_y,
    output elp_pkg::t_flags                     o_flags,
    output logic                                o_ovf,
    output logic [elp_pkg::OUT_W-1:0]           o_data
);

    localparam int KW = elp_pkg::K_W;
    localparam int SW = elp_pkg::SUM_W;
    localparam int NT = elp_pkg::EXP_TERMS;

    logic signed [32:0] w_ln2;
    logic signed [32:0] w_recip;
    assign w_ln2   = $signed({1'b0, elp_pkg::LN2_Q32});
    assign w_recip = $signed({1'b0, elp_pkg::EXP_RECIP});

    // reciprocal estimate of k
    logic signed [64:0]                n_m;
    logic signed [64:0]                r_m;
    logic signed [elp_pkg::COEF_W-1:0] r_y1;
    elp_pkg::t_flags                   r_flg1;
    assign n_m = i_y * w_recip;

    // remainder against the estimate
    logic signed [KW-1:0]              w_kest;
    logic signed [39:0]                w_yw;
    logic signed [42:0]                w_kl;
    logic signed [42:0]                w_r0;
    logic signed [KW-1:0]              r_k2;
    logic signed [34:0]                r_r0;
    elp_pkg::t_flags                   r_flg2;
    assign w_kest = $signed(r_m[64:55]);
    assign w_yw   = $signed({r_y1, 8'b0});
    assign w_kl   = w_kest * w_ln2;
    assign w_r0   = 43'(w_yw) - w_kl;

    // correct k by one either way
    logic signed [34:0]   w_ln2w;
    logic signed [34:0]   w_rr;
    logic signed [KW-1:0] n_k3;
    assign w_ln2w = $signed({3'b0, elp_pkg::LN2_Q32});

    always_comb begin
        if (r_r0 < 35'sd0) begin
            w_rr = r_r0 + w_ln2w;
            n_k3 = r_k2 - KW'(1);
        end else if (r_r0 >= w_ln2w) begin
            w_rr = r_r0 - w_ln2w;
            n_k3 = r_k2 + KW'(1);
        end else begin
            w_rr = r_r0;
            n_k3 = r_k2;
        end
    end

    logic signed [KW-1:0] s_k    [0:NT-1];
    logic [31:0]          s_r    [0:NT-1];
    logic [31:0]          s_term [0:NT-1];
    logic [SW-1:0]        s_sum  [0:NT-1];
    elp_pkg::t_flags      s_flg  [0:NT-1];

    logic signed [KW-1:0] r_k3;
    logic [31:0]          r_r3;
    logic [SW-1:0]        r_sum3;
    elp_pkg::t_flags      r_flg3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flg1 <= '0;
            r_flg2 <= '0;
            r_flg3 <= '0;
        end else if (i_en) begin
            r_flg1 <= i_flags;
            r_flg2 <= r_flg1;
            r_flg3 <= r_flg2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m    <= n_m;
            r_y1   <= i_y;
            r_k2   <= w_kest;
            r_r0   <= w_r0[34:0];
            r_k3   <= n_k3;
            r_r3   <= w_rr[31:0];
            r_sum3 <= SW'(64'h1_0000_0000) + SW'(w_rr[31:0]);
        end
    end

    assign s_k[0]    = r_k3;
    assign s_r[0]    = r_r3;
    assign s_term[0] = r_r3;
    assign s_sum[0]  = r_sum3;
    assign s_flg[0]  = r_flg3;

    for (genvar g = 0; g < NT - 1; g++) begin : g_term
        localparam int          TermN = g + 2;
        localparam logic [32:0] DIV_M = 33'(64'h2_0000_0000 / TermN);
        localparam logic [3:0]  TN    = 4'(TermN);

        logic [63:0]          w_tp;
        logic [31:0]          r_v_a;
        logic signed [KW-1:0] r_k_a;
        logic [31:0]          r_r_a;
        logic [SW-1:0]        r_sum_a;
        elp_pkg::t_flags      r_flg_a;

        logic [63:0]          r_qm;
        logic [31:0]          r_v_b;
        logic signed [KW-1:0] r_k_b;
        logic [31:0]          r_r_b;
        logic [SW-1:0]        r_sum_b;
        elp_pkg::t_flags      r_flg_b;

        logic [31:0]          w_q;
        logic [35:0]          w_rem;
        logic [31:0]          n_term;
        logic [31:0]          r_term;
        logic signed [KW-1:0] r_k;
        logic [31:0]          r_r;
        logic [SW-1:0]        r_sum;
        elp_pkg::t_flags      r_flg;

        assign w_tp   = 64'(s_term[g]) * 64'(s_r[g]);
        assign w_q    = 32'(r_qm[63:33]);
        assign w_rem  = 36'(r_v_b) - 36'(w_q) * 36'(TN);
        assign n_term = (w_rem >= 36'(TN)) ? w_q + 32'd1 : w_q;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_flg_a <= '0;
                r_flg_b <= '0;
                r_flg   <= '0;
            end else if (i_en) begin
                r_flg_a <= s_flg[g];
                r_flg_b <= r_flg_a;
                r_flg   <= r_flg_b;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v_a   <= w_tp[63:32];
                r_k_a   <= s_k[g];
                r_r_a   <= s_r[g];
                r_sum_a <= s_sum[g];
                r_qm    <= 64'(r_v_a) * 64'(DIV_M);
                r_v_b   <= r_v_a;
                r_k_b   <= r_k_a;
                r_r_b   <= r_r_a;
                r_sum_b <= r_sum_a;
                r_term  <= n_term;
                r_k     <= r_k_b;
                r_r     <= r_r_b;
                r_sum   <= r_sum_b + SW'(n_term);
            end
        end

        assign s_k[g+1]    = r_k;
        assign s_r[g+1]    = r_r;
        assign s_term[g+1] = r_term;
        assign s_sum[g+1]  = r_sum;
        assign s_flg[g+1]  = r_flg;
    end

    // scale by 2^(k-8)
    logic signed [KW-1:0]       w_k;
    logic [SW-1:0]              w_sum;
    logic signed [KW-1:0]       w_rs;
    logic [5:0]                 w_sa;
    logic [34:0]                w_half;
    logic [34:0]                w_add;
    logic [2:0]                 w_up;
    logic [elp_pkg::OUT_W-1:0]  n_data;
    logic                       n_ovf;
    logic [elp_pkg::OUT_W-1:0]  r_data;
    logic                       r_ovf;
    elp_pkg::t_flags            r_flg_o;

    assign w_k    = s_k[NT-1];
    assign w_sum  = s_sum[NT-1];
    assign w_rs   = KW'(8) - w_k;
    assign w_sa   = w_rs[5:0];
    assign w_half = 35'd1 << (w_sa - 6'd1);
    assign w_add  = 35'(w_sum) + w_half;
    assign w_up   = 3'(w_k - KW'(8));

    always_comb begin
        n_ovf = 1'b0;
        if (s_flg[NT-1].invalid) begin
            n_data = '0;
        end else if (w_k >= KW'(16)) begin
            n_data = elp_pkg::OUT_MAX;
            n_ovf  = 1'b1;
        end else if (w_k >= KW'(8)) begin
            n_data = elp_pkg::OUT_W'(w_sum) << w_up;
        end else if (w_rs >= KW'(34)) begin
            n_data = '0;
        end else begin
            n_data = elp_pkg::OUT_W'(w_add >> w_sa);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flg_o <= '0;
        end else if (i_en) begin
            r_flg_o <= s_flg[NT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
            r_ovf  <= n_ovf;
        end
    end

    assign o_flags = r_flg_o;
    assign o_ovf   = r_ovf;
    assign o_data  = r_data;

endmodule

@@ sim/elp_checker.sv @@
// Scoreboard for the exp log polynomial evaluator: tracks the coefficient registers,
// predicts exp(p(ln T)) for every temperature transfer and compares the results.
// Depends on elp_pkg.
module elp_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [elp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_temp_valid,
    input  logic                          i_temp_ready,
    input  logic [23:0]                   i_temp,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic [47:0]                   i_res_value,
    input  logic [1:0]                    i_res_flags,
    output int                            o_fail_count,
    output int                            o_open_count
);

    localparam longint LN2_FIX = 64'd2977044472;
    localparam longint ACC_HI  = 64'sd2147483647;
    localparam longint ACC_LO  = -64'sd2147483648;

    typedef struct packed {
        logic [47:0] value;
        logic        overflow;
        logic        invalid;
    } t_curve_point;

    logic [2:0]         coef_count;
    logic signed [31:0] coef [elp_pkg::COEF_REGS];
    t_curve_point       expected_points [$];

    function automatic longint round_away(longint v, int s);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        m = (m + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint ln_fix(logic [23:0] t);
        int k;
        longint unsigned x;
        longint unsigned frac;
        k = 0;
        frac = 0;
        for (int i = 0; i < 24; i++)
            if (t[i]) k = i;
        x = longint'(t) << (30 - k);
        for (int i = 0; i < elp_pkg::LOG_ITERS; i++) begin
            x = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (64'd1 << 31)) begin
                frac = frac | 1;
                x = x >> 1;
            end
        end
        return round_away(((longint'(k) - 8) * 16777216 + longint'(frac)) * LN2_FIX, 32);
    endfunction

    function automatic t_curve_point eval_point(logic [23:0] t);
        t_curve_point p;
        int n;
        longint lnt, acc, yw, k;
        longint unsigned r, term, sum;
        p = '0;
        if (t == 0) begin
            p.invalid = 1'b1;
            return p;
        end
        n = (coef_count < 1) ? 1 :
            (coef_count > elp_pkg::COEF_REGS) ? elp_pkg::COEF_REGS : coef_count;
        lnt = ln_fix(t);
        acc = longint'(coef[0]);
        for (int i = 1; i < n; i++) begin
            acc = round_away(acc * lnt, 24) + longint'(coef[i]);
            if (acc > ACC_HI) acc = ACC_HI;
            if (acc < ACC_LO) acc = ACC_LO;
        end
        yw = acc * 256;
        if (yw >= 0)
            k = yw / LN2_FIX;
        else
            k = -((-yw + LN2_FIX - 1) / LN2_FIX);
        r = yw - k * LN2_FIX;
        term = 64'd1 << 32;
        sum = term;
        for (int i = 1; i <= elp_pkg::EXP_TERMS; i++) begin
            term = ((term * r) >> 32) / i;
            sum = sum + term;
        end
        if (k >= 16) begin
            p.value = '1;
            p.overflow = 1'b1;
        end else if (k >= 8) begin
            p.value = 48'(sum << (k - 8));
        end else if (8 - k >= 34) begin
            p.value = '0;
        end else begin
            p.value = 48'((sum + (64'd1 << (7 - k))) >> (8 - k));
        end
        return p;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_open_count = 0;
    end

    always @(posedge i_clk) begin
        t_curve_point exp_pt;
        if (!i_rst_n) begin
            coef_count <= 3'd1;
            for (int i = 0; i < elp_pkg::COEF_REGS; i++) coef[i] <= '0;
            expected_points.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == elp_pkg::CFG_COEF_COUNT)
                    coef_count <= i_cfg_data[2:0];
                else if (i_cfg_index - elp_pkg::CFG_COEF_BASE < elp_pkg::COEF_REGS)
                    coef[i_cfg_index - elp_pkg::CFG_COEF_BASE] <= i_cfg_data;
            end
            if (i_temp_valid && i_temp_ready)
                expected_points.insert(expected_points.size(), eval_point(i_temp));
            if (i_res_valid && i_res_ready) begin
                if (expected_points.size() == 0) begin
                    report("unexpected result", i_res_value, 0);
                end else begin
                    exp_pt = expected_points.pop_front();
                    if (i_res_value !== exp_pt.value)
                        report("integral_value", i_res_value, exp_pt.value);
                    if (i_res_flags[0] !== exp_pt.overflow)
                        report("overflow", i_res_flags[0], exp_pt.overflow);
                    if (i_res_flags[1] !== exp_pt.invalid)
                        report("invalid", i_res_flags[1], exp_pt.invalid);
                end
            end
        end
        o_open_count = expected_points.size();
    end
endmodule

@@ sim/testbench.sv @@
// Top of the exp log polynomial evaluator testbench: clock, reset, register phases,
// temperature stimulus with random gaps and back-pressure, and the verdict.
// Depends on elp_pkg, elp_checker and the evaluator RTL.
module testbench;

    localparam logic [elp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int NUM_PHASES = 13;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [elp_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]                   i_cfg_data;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [23:0]                   s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [47:0]                   m_axis_tdata;
    logic [1:0]                    m_axis_tuser;
    int                            fail_count;
    int                            open_count;
    bit                            no_idle;
    bit                            hold_req;

    exp_log_polynomial_evaluator DUT (.*);

    elp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_temp_valid(s_axis_tvalid), .i_temp_ready(s_axis_tready), .i_temp(s_axis_tdata),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_value(m_axis_tdata), .i_res_flags(m_axis_tuser),
        .o_fail_count(fail_count), .o_open_count(open_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8 * 1000000);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else begin
                m_axis_tready <= no_idle || ($urandom_range(99) >= 15);
            end
        end
    end

    task automatic write_reg(logic [elp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic send_temp(logic [23:0] t);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        do @(posedge i_clk); while (!s_axis_tready);
        if (!no_idle && $urandom_range(99) < 15) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_coef();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5) return 32'($signed($urandom_range(0, 32'h7F_FFFF)) - 32'sh40_0000);
        if (sel < 8) return 32'($signed($urandom_range(0, 32'h7FF_FFFF)) - 32'sh400_0000);
        return $urandom();
    endfunction

    function automatic logic [23:0] rand_temp();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0, 1, 2, 3: return 24'($urandom());
            4, 5, 6:    return 24'($urandom_range(51200, 1280000));
            7:          return 24'($urandom_range(0, 255));
            8:          return 24'(1) << $urandom_range(0, 23);
            default:    return (sel[0]) ? 24'hFF_FFFF : 24'($urandom_range(0, 1));
        endcase
    endfunction

    initial begin
        logic [23:0] directed [] = '{24'd0, 24'd1, 24'hFF_FFFF, 24'd256, 24'h800000,
                                     24'd76800, 24'd2};
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        no_idle       = 1'b0;
        hold_req      = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: ;
                1: begin
                    write_reg(elp_pkg::CFG_COEF_COUNT, 32'd1);
                    write_reg(elp_pkg::CFG_COEF_BASE, 32'h7FFF_FFFF);
                end
                2: write_reg(elp_pkg::CFG_COEF_BASE, 32'h8000_0000);
                3: begin
                    write_reg(elp_pkg::CFG_COEF_COUNT, 32'd0);
                    write_reg(elp_pkg::CFG_COEF_BASE, 32'h0100_0000);
                end
                4: begin
                    write_reg(elp_pkg::CFG_COEF_COUNT, 32'd7);
                    for (int i = 0; i < elp_pkg::COEF_REGS; i++)
                        write_reg(3'(elp_pkg::CFG_COEF_BASE + i), rand_coef());
                end
                5: for (int i = 0; i < elp_pkg::COEF_REGS; i++)
                    write_reg(3'(elp_pkg::CFG_COEF_BASE + i), 32'h7FFF_FFFF);
                6: begin
                    write_reg(CFG_UNUSED, $urandom());
                    write_reg(elp_pkg::CFG_COEF_COUNT, 32'd6);
                    for (int i = 0; i < elp_pkg::COEF_REGS; i++)
                        write_reg(3'(elp_pkg::CFG_COEF_BASE + i),
                                  (i == 0) ? 32'h8000_0000 : rand_coef());
                end
                default: begin
                    write_reg(elp_pkg::CFG_COEF_COUNT,
                              $urandom_range(0, 7) | ($urandom() << 3));
                    for (int i = 0; i < elp_pkg::COEF_REGS; i++)
                        write_reg(3'(elp_pkg::CFG_COEF_BASE + i), rand_coef());
                end
            endcase
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
            no_idle = (ph == 7);
            if (ph == 8) hold_req = 1'b1;
            if (ph < 6)
                foreach (directed[i]) send_temp(directed[i]);
            for (int i = 0; i < 85; i++) send_temp(rand_temp());
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while (open_count != 0) @(posedge i_clk);
        end

        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+src
src/elp_pkg.sv
src/elp_log.sv
src/elp_horner.sv
src/elp_exp.sv
src/exp_log_polynomial_evaluator.sv
sim/elp_checker.sv
sim/testbench.sv
